### rtl/dlw_pkg.sv
// Package for the descriptor loop walker: field widths, payload structs,
// phase and register codes. No dependencies.
package dlw_pkg;

	localparam int MAX_LEN_DEF = 4096;

	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 12;
	localparam int TOTAL_W  = 13;
	localparam int OFFSET_W = 12;
	localparam int WIDX_W   = 11;

	localparam int HDR_BYTES = 2;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TAG   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WANTED_INDEX = 1'd1;

	localparam int PHASE_W = 2;
	localparam logic [PHASE_W-1:0] PH_TAG  = 2'd0;
	localparam logic [PHASE_W-1:0] PH_LEN  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_BODY = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              byte_present;
		logic              end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  descriptor_count;
		logic [TOTAL_W-1:0]  total_length;
		logic                tag_found;
		logic [OFFSET_W-1:0] tag_offset;
		logic                index_found;
		logic [OFFSET_W-1:0] index_offset;
	} result_t;

	typedef struct packed {
		logic    emit;
		result_t res;
	} walk_res_t;

	typedef struct packed {
		logic [BYTE_W-1:0] search_tag;
		logic [WIDX_W-1:0] wanted_index;
	} cfg_regs_t;

endpackage

### rtl/dlw_if.sv
// Channel interfaces for the descriptor loop walker: input items, results
// and register writes. Depends on dlw_pkg.
interface dlw_in_if import dlw_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dlw_out_if import dlw_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dlw_cfg_if import dlw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

### rtl/descriptor_loop_tlv_walker.sv
// Top level of the descriptor loop walker: register block, walker and
// result register. Depends on dlw_pkg, dlw_if and the dlw_* modules.
//
//   channel  | dir | carries
//   item_in  | in  | data_byte, byte_present, end_of_buffer
//   result   | out | count, total length, tag and index offsets with flags
//   cfg      | in  | register index and write data (search_tag, wanted_index)
//
// One item a cycle; the walk state advances in the cycle an item is taken.
// A result is visible the cycle after its end-of-buffer item is taken.
// item_in stalls only while a result waits in the output register.
// Reset clears the registers, the walk state and the result valid; no clearing pass.
module descriptor_loop_tlv_walker import dlw_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dlw_in_if.sink    item_in,
	dlw_out_if.source result,
	dlw_cfg_if.sink   cfg
);

	cfg_regs_t regs;
	walk_res_t walk;
	logic      can_take;
	logic      take;

	assign item_in.ready = can_take;
	assign take          = item_in.valid && can_take;

	dlw_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	dlw_walker #(
		.MAX_LEN (MAX_LEN)
	) u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_in.data),
		.regs   (regs),
		.walk   (walk)
	);

	dlw_result_reg u_res (
		.clk      (clk),
		.arst_n   (arst_n),
		.walk     (walk),
		.can_take (can_take),
		.result   (result)
	);

endmodule

### rtl/dlw_cfg_regs.sv
// Configuration registers: search tag and wanted index, written through
// the register write channel. Depends on dlw_pkg and dlw_if.
module dlw_cfg_regs import dlw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dlw_cfg_if.sink   cfg,
	output cfg_regs_t regs
);

	logic [BYTE_W-1:0] search_tag_q;
	logic [WIDX_W-1:0] wanted_index_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_tag_q   <= '0;
			wanted_index_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SEARCH_TAG:   search_tag_q   <= cfg.wdata[BYTE_W-1:0];
				CFG_WANTED_INDEX: wanted_index_q <= cfg.wdata[WIDX_W-1:0];
				default: ;
			endcase
		end
	end

	assign regs.search_tag   = search_tag_q;
	assign regs.wanted_index = wanted_index_q;

endmodule

### rtl/dlw_walker.sv
// Walk state of the descriptor loop: phase, counters and found offsets,
// advanced by at most one byte per accepted item. Depends on dlw_pkg.
module dlw_walker import dlw_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  in_item_t  item,
	input  cfg_regs_t regs,
	output walk_res_t walk
);

	localparam int POS_RAW = $clog2(MAX_LEN + 1);
	localparam int CNT_RAW = $clog2(MAX_LEN / HDR_BYTES + 1);
	localparam int OFS_RAW = $clog2(MAX_LEN);
	localparam int POS_W   = (POS_RAW > TOTAL_W) ? POS_RAW : TOTAL_W;
	localparam int CNT_W   = (CNT_RAW > COUNT_W) ? CNT_RAW : COUNT_W;
	localparam int OFS_W   = (OFS_RAW > OFFSET_W) ? OFS_RAW : OFFSET_W;
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [BYTE_W-1:0]  held_tag_q, held_tag_d;
	logic [BYTE_W-1:0]  body_left_q, body_left_d;
	logic [POS_W-1:0]   pos_q, pos_d, pos_inc;
	logic [OFS_W-1:0]   start_q, start_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [POS_W-1:0]   bytes_q, bytes_d;
	logic               match_seen_q, match_seen_d;
	logic [OFS_W-1:0]   match_ofs_q, match_ofs_d;
	logic               index_seen_q, index_seen_d;
	logic [OFS_W-1:0]   index_ofs_q, index_ofs_d;
	logic [BYTE_W-1:0]  body_dec;
	logic               finish;

	assign pos_inc  = pos_q + POS_W'(1);
	assign body_dec = (body_left_q != '0) ? body_left_q - BYTE_W'(1) : '0;

	always_comb begin
		phase_d      = phase_q;
		held_tag_d   = held_tag_q;
		body_left_d  = body_left_q;
		pos_d        = pos_q;
		start_d      = start_q;
		count_d      = count_q;
		bytes_d      = bytes_q;
		match_seen_d = match_seen_q;
		match_ofs_d  = match_ofs_q;
		index_seen_d = index_seen_q;
		index_ofs_d  = index_ofs_q;
		finish       = 1'b0;

		if (item.byte_present && (pos_q < POS_LIMIT)) begin
			pos_d = pos_inc;
			case (phase_q)
				PH_TAG: begin
					held_tag_d = item.data_byte;
					start_d    = pos_q[OFS_W-1:0];
					phase_d    = PH_LEN;
				end
				PH_LEN: begin
					if (item.data_byte == '0) begin
						finish = 1'b1;
					end else begin
						body_left_d = item.data_byte;
						phase_d     = PH_BODY;
					end
				end
				default: begin
					body_left_d = body_dec;
					finish      = (body_dec == '0);
				end
			endcase
		end

		if (finish) begin
			if (!match_seen_q && (held_tag_q == regs.search_tag)) begin
				match_seen_d = 1'b1;
				match_ofs_d  = start_q;
			end
			if (!index_seen_q && (count_q == CNT_W'(regs.wanted_index))) begin
				index_seen_d = 1'b1;
				index_ofs_d  = start_q;
			end
			count_d = count_q + CNT_W'(1);
			bytes_d = pos_inc;
			phase_d = PH_TAG;
		end
	end

	always_comb begin
		walk.emit                 = take && item.end_of_buffer;
		walk.res.descriptor_count = count_d[COUNT_W-1:0];
		walk.res.total_length     = bytes_d[TOTAL_W-1:0];
		walk.res.tag_found        = match_seen_d;
		walk.res.tag_offset       = match_seen_d ? match_ofs_d[OFFSET_W-1:0] : '0;
		walk.res.index_found      = index_seen_d;
		walk.res.index_offset     = index_seen_d ? index_ofs_d[OFFSET_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TAG;
			held_tag_q   <= '0;
			body_left_q  <= '0;
			pos_q        <= '0;
			start_q      <= '0;
			count_q      <= '0;
			bytes_q      <= '0;
			match_seen_q <= 1'b0;
			match_ofs_q  <= '0;
			index_seen_q <= 1'b0;
			index_ofs_q  <= '0;
		end else if (take) begin
			if (item.end_of_buffer) begin
				// clear the walk once the result is taken over
				phase_q      <= PH_TAG;
				held_tag_q   <= '0;
				body_left_q  <= '0;
				pos_q        <= '0;
				start_q      <= '0;
				count_q      <= '0;
				bytes_q      <= '0;
				match_seen_q <= 1'b0;
				match_ofs_q  <= '0;
				index_seen_q <= 1'b0;
				index_ofs_q  <= '0;
			end else begin
				phase_q      <= phase_d;
				held_tag_q   <= held_tag_d;
				body_left_q  <= body_left_d;
				pos_q        <= pos_d;
				start_q      <= start_d;
				count_q      <= count_d;
				bytes_q      <= bytes_d;
				match_seen_q <= match_seen_d;
				match_ofs_q  <= match_ofs_d;
				index_seen_q <= index_seen_d;
				index_ofs_q  <= index_ofs_d;
			end
		end
	end

endmodule

### rtl/dlw_result_reg.sv
// Result output register: holds one result until taken and tells the
// input side when an item may enter. Depends on dlw_pkg and dlw_if.
module dlw_result_reg import dlw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  walk_res_t walk,
	output logic      can_take,
	dlw_out_if.source result
);

	logic    valid_q;
	result_t data_q;

	assign can_take = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (walk.emit) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (walk.emit) begin
			data_q <= walk.res;
		end
	end

	assign result.valid = valid_q;
	assign result.data  = data_q;

endmodule
